[hdl/sfa_pkg.sv]
// Shared codes, defaults and control/status bundles for the segment fit allocator.
package sfa_pkg;

  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int OFFSET_BITS_DEF  = 20;

  // field widths of the stream words
  localparam int REQ_W    = 21;
  localparam int REL_W    = 20;
  localparam int STATUS_W = 3;
  localparam int GRANT_W  = 20;
  localparam int SCOUNT_W = 7;
  localparam int CFG_W    = 21;
  localparam int NEED_W   = REQ_W + 1;

  // register indexes
  localparam logic REG_FIT_MODE   = 1'b0;
  localparam logic REG_ARENA_SIZE = 1'b1;

  // placement policies
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_NEXT  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;
  localparam logic [1:0] FIT_BEST  = 2'd3;

  // operation kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STS_GRANTED   = 3'd0;
  localparam logic [STATUS_W-1:0] STS_NO_FIT    = 3'd1;
  localparam logic [STATUS_W-1:0] STS_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] STS_FREED     = 3'd3;
  localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd4;

  // datapath steps
  localparam logic [3:0] STEP_NOP    = 4'd0;
  localparam logic [3:0] STEP_INIT   = 4'd1;
  localparam logic [3:0] STEP_LOAD   = 4'd2;
  localparam logic [3:0] STEP_SCAN   = 4'd3;
  localparam logic [3:0] STEP_DECIDE = 4'd4;
  localparam logic [3:0] STEP_SHUP   = 4'd5;
  localparam logic [3:0] STEP_WSPLIT = 4'd6;
  localparam logic [3:0] STEP_WPICK  = 4'd7;
  localparam logic [3:0] STEP_FRD    = 4'd8;
  localparam logic [3:0] STEP_WMERGE = 4'd9;
  localparam logic [3:0] STEP_SHDN   = 4'd10;
  localparam logic [3:0] STEP_FDONE  = 4'd11;
  localparam logic [3:0] STEP_WFREE  = 4'd12;
  localparam logic [3:0] STEP_RESP   = 4'd13;

  typedef struct packed {
    logic [3:0]          step;
    logic [STATUS_W-1:0] code;
  } sfa_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic zero;
    logic split;
    logic full;
    logic is_free;
    logic has_next;
    logic next_free;
    logic shift_done;
    logic out_free;
  } sfa_sts_t;

endpackage

[hdl/sfa_ctrl.sv]
// Sequencing state machine of the segment fit allocator.
module sfa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  sfa_pkg::sfa_sts_t sts,
  output sfa_pkg::sfa_cmd_t cmd
);
  import sfa_pkg::*;

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_SHUP   = 4'd4;
  localparam logic [3:0] S_WSPLIT = 4'd5;
  localparam logic [3:0] S_WPICK  = 4'd6;
  localparam logic [3:0] S_FRD    = 4'd7;
  localparam logic [3:0] S_FEVAL  = 4'd8;
  localparam logic [3:0] S_WMERGE = 4'd9;
  localparam logic [3:0] S_SHDN   = 4'd10;
  localparam logic [3:0] S_FDONE  = 4'd11;
  localparam logic [3:0] S_WFREE  = 4'd12;
  localparam logic [3:0] S_RESP   = 4'd13;

  logic [3:0]          state_r, state_nxt;
  logic [STATUS_W-1:0] code_r, code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      code_r  <= STS_GRANTED;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    cmd.code  = code_r;
    cmd.step  = STEP_NOP;
    unique case (state_r)
      S_INIT: begin
        cmd.step  = STEP_INIT;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.step  = STEP_LOAD;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = STEP_SCAN;
        if (sts.scan_done) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.step = STEP_DECIDE;
        if (sts.is_free) begin
          if (!sts.found) begin
            code_nxt  = STS_NOT_FOUND;
            state_nxt = S_RESP;
          end else if (sts.has_next) begin
            state_nxt = S_FRD;
          end else begin
            state_nxt = S_WFREE;
          end
        end else if (sts.zero || !sts.found) begin
          code_nxt  = STS_NO_FIT;
          state_nxt = S_RESP;
        end else if (sts.split) begin
          if (sts.full) begin
            code_nxt  = STS_FULL;
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_SHUP;
          end
        end else begin
          state_nxt = S_WPICK;
        end
      end
      S_SHUP: begin
        cmd.step = STEP_SHUP;
        if (sts.shift_done) state_nxt = S_WSPLIT;
      end
      S_WSPLIT: begin
        cmd.step  = STEP_WSPLIT;
        state_nxt = S_WPICK;
      end
      S_WPICK: begin
        cmd.step  = STEP_WPICK;
        code_nxt  = STS_GRANTED;
        state_nxt = S_RESP;
      end
      S_FRD: begin
        cmd.step  = STEP_FRD;
        state_nxt = S_FEVAL;
      end
      S_FEVAL: begin
        state_nxt = sts.next_free ? S_WMERGE : S_WFREE;
      end
      S_WMERGE: begin
        cmd.step  = STEP_WMERGE;
        state_nxt = S_SHDN;
      end
      S_SHDN: begin
        cmd.step = STEP_SHDN;
        if (sts.shift_done) state_nxt = S_FDONE;
      end
      S_FDONE: begin
        cmd.step  = STEP_FDONE;
        code_nxt  = STS_FREED;
        state_nxt = S_RESP;
      end
      S_WFREE: begin
        cmd.step  = STEP_WFREE;
        code_nxt  = STS_FREED;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.step  = STEP_RESP;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

endmodule

[hdl/sfa_datapath.sv]
// Segment table memory, scan and shift counters, and result register.
module sfa_datapath #(
  parameter int MAX_SEGMENTS = sfa_pkg::MAX_SEGMENTS_DEF,
  parameter int OFFSET_BITS  = sfa_pkg::OFFSET_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sfa_pkg::sfa_cmd_t             cmd,
  output sfa_pkg::sfa_sts_t             sts,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [sfa_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_kind,
  input  logic [sfa_pkg::REQ_W-1:0]     in_req,
  input  logic [sfa_pkg::REL_W-1:0]     in_rel,
  input  logic                          out_tready,
  output logic                          out_valid,
  output logic [sfa_pkg::STATUS_W-1:0]  out_status,
  output logic [sfa_pkg::GRANT_W-1:0]   out_grant,
  output logic [sfa_pkg::SCOUNT_W-1:0]  out_count
);
  import sfa_pkg::*;

  localparam int OFF_W = OFFSET_BITS;
  localparam int LEN_W = OFFSET_BITS + 1;
  localparam int IDX_W = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int CW    = (LEN_W > NEED_W) ? LEN_W : NEED_W;
  localparam logic [CW-1:0] LIMIT = CW'(64'(1) << OFFSET_BITS);
  localparam logic [CW-1:0] RST_ARENA = (LIMIT < CW'(1048576)) ? LIMIT : CW'(1048576);

  typedef struct packed {
    logic [OFF_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic             taken;
  } entry_t;

  entry_t mem_r [MAX_SEGMENTS];
  entry_t rd_r;

  logic [1:0]        fit_r;
  logic [LEN_W-1:0]  arena_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  rover_r, rover_nxt;
  logic              kind_r;
  logic [NEED_W-1:0] need_r;
  logic              zero_r;
  logic [REL_W-1:0]  rel_r;
  logic [CNT_W-1:0]  k_r;
  logic [IDX_W-1:0]  first_r;
  logic              pend_r;
  logic [IDX_W-1:0]  pidx_r;
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  pick_r, pick_nxt;
  logic [OFF_W-1:0]  pstart_r, pstart_nxt;
  logic [LEN_W-1:0]  plen_r, plen_nxt;
  logic [CNT_W-1:0]  sh_r;
  logic              spend_r;
  logic [IDX_W-1:0]  sidx_r;

  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_wa, mem_ra;
  entry_t            mem_wd;

  function automatic logic [LEN_W-1:0] clamp_arena(input logic [CFG_W-1:0] v);
    logic [CW-1:0] r;
    r = (CW'(v) + CW'(3)) & ~CW'(3);
    if (r < CW'(4)) r = CW'(4);
    if (r > LIMIT) r = LIMIT;
    return LEN_W'(r);
  endfunction

  // scan bookkeeping
  logic             early, halt, issue, eval;
  logic [CNT_W:0]   sum;
  logic [IDX_W-1:0] scan_idx;
  logic [CW-1:0]    e_len, p_len, need_c;
  logic             fit_ok, hit;
  logic [CNT_W-1:0] pick1;
  logic             sh_issue;

  assign early  = kind_r || (fit_r == FIT_FIRST) || (fit_r == FIT_NEXT);
  assign halt   = found_r && early;
  assign issue  = (k_r < count_r) && !halt;
  assign eval   = pend_r && !halt;
  assign sum    = {1'b0, k_r} + (CNT_W + 1)'(first_r);
  assign scan_idx = (sum >= {1'b0, count_r}) ? IDX_W'(sum - {1'b0, count_r}) : IDX_W'(sum);
  assign e_len  = CW'(rd_r.len);
  assign p_len  = CW'(plen_r);
  assign need_c = CW'(need_r);
  assign fit_ok = !rd_r.taken && (e_len >= need_c);
  assign hit    = kind_r ? (rd_r.taken && (32'(rd_r.start) == 32'(rel_r))) : fit_ok;
  assign pick1  = CNT_W'(pick_r) + CNT_W'(1);
  assign sh_issue = kind_r ? (sh_r < count_r) : (sh_r > pick1);

  always_comb begin
    found_nxt  = found_r;
    pick_nxt   = pick_r;
    pstart_nxt = pstart_r;
    plen_nxt   = plen_r;
    if (eval && hit) begin
      if (!found_r || (!kind_r && fit_r == FIT_WORST && e_len > p_len) ||
          (!kind_r && fit_r == FIT_BEST && e_len < p_len)) begin
        found_nxt  = 1'b1;
        pick_nxt   = pidx_r;
        pstart_nxt = rd_r.start;
        plen_nxt   = rd_r.len;
      end
    end
  end

  // memory port selection
  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_wa = '0;
    mem_ra = '0;
    mem_wd = '{start: '0, len: arena_r, taken: 1'b0};
    case (cmd.step)
      STEP_INIT: mem_we = 1'b1;
      STEP_SCAN: begin
        mem_re = issue;
        mem_ra = scan_idx;
      end
      STEP_SHUP: begin
        mem_re = sh_issue;
        mem_ra = IDX_W'(sh_r - CNT_W'(1));
        mem_we = spend_r;
        mem_wa = sidx_r + IDX_W'(1);
        mem_wd = rd_r;
      end
      STEP_SHDN: begin
        mem_re = sh_issue;
        mem_ra = IDX_W'(sh_r);
        mem_we = spend_r;
        mem_wa = sidx_r - IDX_W'(1);
        mem_wd = rd_r;
      end
      STEP_WSPLIT: begin
        mem_we = 1'b1;
        mem_wa = pick_r + IDX_W'(1);
        mem_wd = '{start: pstart_r + OFF_W'(need_r), len: plen_r - LEN_W'(need_r),
                   taken: 1'b0};
      end
      STEP_WPICK: begin
        mem_we = 1'b1;
        mem_wa = pick_r;
        mem_wd = '{start: pstart_r, len: LEN_W'(need_r), taken: 1'b1};
      end
      STEP_FRD: begin
        mem_re = 1'b1;
        mem_ra = pick_r + IDX_W'(1);
      end
      STEP_WMERGE: begin
        mem_we = 1'b1;
        mem_wa = pick_r;
        mem_wd = '{start: pstart_r, len: plen_r + rd_r.len, taken: 1'b0};
      end
      STEP_WFREE: begin
        mem_we = 1'b1;
        mem_wa = pick_r;
        mem_wd = '{start: pstart_r, len: plen_r, taken: 1'b0};
      end
      default: ;
    endcase
    // a register write rebuilds the table as one free segment
    if (cfg_we) begin
      mem_we = 1'b1;
      mem_wa = '0;
      mem_wd = '{start: '0, len: (cfg_index == REG_ARENA_SIZE) ? clamp_arena(cfg_wdata)
                                                                : arena_r, taken: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_r[mem_wa] <= mem_wd;
    if (mem_re) rd_r <= mem_r[mem_ra];
  end

  always_comb begin
    count_nxt = count_r;
    rover_nxt = rover_r;
    case (cmd.step)
      STEP_WPICK: begin
        rover_nxt = pick_r;
        if (p_len > need_c) count_nxt = count_r + CNT_W'(1);
      end
      STEP_FDONE: begin
        count_nxt = count_r - CNT_W'(1);
        if (CNT_W'(rover_r) > pick1) rover_nxt = rover_r - IDX_W'(1);
        else if (CNT_W'(rover_r) == pick1) rover_nxt = pick_r;
      end
      default: ;
    endcase
    if (cmd.step == STEP_INIT || cfg_we) begin
      count_nxt = CNT_W'(1);
      rover_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_r     <= FIT_FIRST;
      arena_r   <= LEN_W'(RST_ARENA);
      count_r   <= CNT_W'(1);
      rover_r   <= '0;
      pend_r    <= 1'b0;
      spend_r   <= 1'b0;
      found_r   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      count_r <= count_nxt;
      rover_r <= rover_nxt;
      if (cfg_we) begin
        if (cfg_index == REG_FIT_MODE) fit_r <= cfg_wdata[1:0];
        else arena_r <= clamp_arena(cfg_wdata);
      end
      if (cmd.step == STEP_RESP) out_valid <= 1'b1;
      else if (out_valid && out_tready) out_valid <= 1'b0;
      case (cmd.step)
        STEP_LOAD: begin
          kind_r  <= in_kind;
          need_r  <= (NEED_W'(in_req) + NEED_W'(3)) & ~NEED_W'(3);
          zero_r  <= (in_req == '0);
          rel_r   <= in_rel;
          k_r     <= '0;
          pend_r  <= 1'b0;
          found_r <= 1'b0;
          first_r <= (in_kind == KIND_ALLOC && fit_r == FIT_NEXT &&
                      CNT_W'(rover_r) < count_r) ? rover_r : '0;
        end
        STEP_SCAN: begin
          if (issue) k_r <= k_r + CNT_W'(1);
          pend_r   <= issue;
          pidx_r   <= scan_idx;
          found_r  <= found_nxt;
          pick_r   <= pick_nxt;
          pstart_r <= pstart_nxt;
          plen_r   <= plen_nxt;
        end
        STEP_DECIDE: begin
          sh_r    <= count_r;
          spend_r <= 1'b0;
        end
        STEP_WMERGE: begin
          sh_r    <= pick1 + CNT_W'(1);
          spend_r <= 1'b0;
        end
        STEP_SHUP: begin
          if (sh_issue) sh_r <= sh_r - CNT_W'(1);
          spend_r <= sh_issue;
          sidx_r  <= IDX_W'(sh_r - CNT_W'(1));
        end
        STEP_SHDN: begin
          if (sh_issue) sh_r <= sh_r + CNT_W'(1);
          spend_r <= sh_issue;
          sidx_r  <= IDX_W'(sh_r);
        end
        STEP_RESP: begin
          out_status <= cmd.code;
          out_grant  <= (cmd.code == STS_GRANTED) ? GRANT_W'(32'(pstart_r)) : '0;
          out_count  <= SCOUNT_W'(32'(count_r));
        end
        default: ;
      endcase
    end
  end

  assign sts.scan_done  = (!pend_r && k_r >= count_r) || halt;
  assign sts.found      = found_r;
  assign sts.zero       = zero_r;
  assign sts.split      = p_len > need_c;
  assign sts.full       = count_r >= CNT_W'(MAX_SEGMENTS);
  assign sts.is_free    = kind_r;
  assign sts.has_next   = pick1 < count_r;
  assign sts.next_free  = !rd_r.taken;
  assign sts.shift_done = !sh_issue && !spend_r;
  assign sts.out_free   = !out_valid || out_tready;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0 && count_r <= CNT_W'(MAX_SEGMENTS))
    else $error("segment count out of range");
  a_rover_live: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(rover_r) < count_r)
    else $error("rover beyond live segments");
  a_pick_found: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step == STEP_WPICK || cmd.step == STEP_WFREE || cmd.step == STEP_WMERGE) |-> found_r)
    else $error("table write without a chosen segment");
  a_split_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step == STEP_WSPLIT |=> count_r < CNT_W'(MAX_SEGMENTS) || $past(cfg_we))
    else $error("split with a full table");

endmodule

[hdl/segment_fit_allocator.sv]
// Top level of the segment fit allocator: stream ports, controller and datapath.
//
// Keeps an address-ordered table of arena segments in a single memory (one write
// and one registered read port). One word in, one word out. An allocate word
// scans the live segments one per cycle (pipelined reads; first and next fit
// stop at the first hit, worst and best fit read all), then inserts a split
// tail by shifting the entries above the pick up one per cycle. A free word
// scans for the taken segment at the offset, reads its follower and, on a
// merge, shifts the entries above down one per cycle. The time an item takes
// grows with the live segment count, as the scan and the shift walk the single
// memory port. After reset the init state writes the initial free segment
// before the first word is taken. The result sits in an output register, so a
// new word is accepted while it waits; the next result waits for that register.
// Configuration writes rebuild the table in the same cycle; the user must make
// them only while the block is idle, as the block itself does not enforce it.
module segment_fit_allocator #(
  parameter int MAX_SEGMENTS = sfa_pkg::MAX_SEGMENTS_DEF,
  parameter int OFFSET_BITS  = sfa_pkg::OFFSET_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_index,  // 0 fit_mode, 1 arena_bytes
  input  logic [sfa_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [47:0]               in_tdata,   // request_bytes[20:0], release_offset[40:21]
  input  logic                      in_tuser,   // kind
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [31:0]               out_tdata   // status[2:0], grant_offset[22:3],
                                                // segment_count[29:23]
);
  import sfa_pkg::*;

  sfa_cmd_t cmd;
  sfa_sts_t sts;

  logic [STATUS_W-1:0] o_status;
  logic [GRANT_W-1:0]  o_grant;
  logic [SCOUNT_W-1:0] o_count;

  sfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sfa_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .OFFSET_BITS  (OFFSET_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_kind    (in_tuser),
    .in_req     (in_tdata[20:0]),
    .in_rel     (in_tdata[40:21]),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_status (o_status),
    .out_grant  (o_grant),
    .out_count  (o_count)
  );

  // pack result word, upper bits zero
  assign out_tdata = {2'b00, o_count, o_grant, o_status};

endmodule
